FILE: src/bfr_pkg.sv
// shared types and constants for the byte stuffed frame receiver
package bfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 8;
    localparam int ERR_W        = 16;
    localparam int CFG_INDEX_W  = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FLAG   = 2'd0,
        CFG_ESCAPE = 2'd1,
        CFG_MASK   = 2'd2,
        CFG_LENGTH = 2'd3
    } cfg_index_t;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0]  FLAG_RESET   = 8'd126;
    localparam logic [BYTE_W-1:0]  ESCAPE_RESET = 8'd125;
    localparam logic [BYTE_W-1:0]  MASK_RESET   = 8'd32;
    localparam logic [COUNT_W-1:0] LENGTH_RESET = 8'd8;

    typedef struct packed {
        logic [BYTE_W-1:0]  flag_byte;
        logic [BYTE_W-1:0]  escape_byte;
        logic [BYTE_W-1:0]  xor_mask;
        logic [COUNT_W-1:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic               in_frame;
        logic               escape_pending;
        logic               error_pending;
        logic [COUNT_W-1:0] received_count;
        logic [ERR_W-1:0]   error_counter;
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] byte_index;
        logic               last_of_frame;
        logic [ERR_W-1:0]   error_total;
    } result_t;

endpackage

FILE: src/bfr_core.sv
// per-byte deframing logic: next state and optional result item
module bfr_core
    import bfr_pkg::*;
(
    input  cfg_t              cfg,
    input  state_t            state,
    input  logic [BYTE_W-1:0] rx_byte,
    output state_t            state_next,
    output result_t           result
);

    logic [COUNT_W-1:0] count_inc;
    logic               is_escape;
    logic               is_flag;

    assign count_inc = state.received_count + COUNT_W'(1);
    assign is_escape = (rx_byte == cfg.escape_byte);
    assign is_flag   = (rx_byte == cfg.flag_byte);

    // decode one byte
    always_comb
    begin
        state_next           = state;
        result.valid         = 1'b0;
        result.data_byte     = rx_byte;
        result.byte_index    = state.received_count;
        result.last_of_frame = (count_inc == cfg.frame_length);
        result.error_total   = state.error_counter;

        if (!state.in_frame)
        begin
            // hunting for a flag
            if (state.escape_pending)
            begin
                state_next.escape_pending = 1'b0;
            end
            else if (is_escape)
            begin
                state_next.escape_pending = 1'b1;
                state_next.error_pending  = 1'b1;
            end
            else if (is_flag)
            begin
                if (state.error_pending)
                begin
                    state_next.error_counter = state.error_counter + ERR_W'(1);
                end
                state_next.error_pending  = 1'b0;
                state_next.received_count = '0;
                state_next.in_frame       = 1'b1;
            end
            else
            begin
                state_next.error_pending = 1'b1;
            end
        end
        else if (!state.escape_pending && is_escape)
        begin
            // escape inside a frame is dropped
            state_next.escape_pending = 1'b1;
        end
        else
        begin
            // data byte inside a frame
            result.valid = 1'b1;
            if (state.escape_pending)
            begin
                result.data_byte = rx_byte ^ cfg.xor_mask;
            end
            state_next.escape_pending = 1'b0;
            if (result.last_of_frame)
            begin
                state_next.received_count = '0;
                state_next.in_frame       = 1'b0;
            end
            else
            begin
                state_next.received_count = count_inc;
            end
        end
    end

endmodule

FILE: src/byte_stuffed_frame_receiver_top.sv
// top level of the byte stuffed frame receiver
// Takes one raw byte per item and emits decoded frame bytes with their index,
// a last-of-frame mark and the running error count. Each byte passes an input
// register and is decoded by a single short logic pass into the output
// register, so one item is accepted every cycle unless a result is held back by
// a stalled output. Input ready is high when the input register is empty or
// can pass its byte on, which needs room in the output register only when
// that byte yields a result; escapes and hunting bytes consume an item
// without producing a result. Configuration must be written only while idle;
// the block itself does not enforce it.
module byte_stuffed_frame_receiver_top
    import bfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BYTE_W-1:0]      data_byte,
    output logic [COUNT_W-1:0]     byte_index,
    output logic                   last_of_frame,
    output logic [ERR_W-1:0]       error_total,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    state_t            state_reg;
    state_t            state_next;
    logic              stage_valid_reg;
    logic [BYTE_W-1:0] stage_byte_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;
    logic              out_load_ok;
    logic              stage_fire;

    // decode of the registered byte
    bfr_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .rx_byte    (stage_byte_reg),
        .state_next (state_next),
        .result     (result)
    );

    // pipeline flow control
    assign out_load_ok = !out_valid_reg || out_ready;
    assign stage_fire  = stage_valid_reg && (!result.valid || out_load_ok);
    assign in_ready    = !stage_valid_reg || stage_fire;

    // configuration write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLAG:   cfg_next.flag_byte    = cfg_data;
                CFG_ESCAPE: cfg_next.escape_byte  = cfg_data;
                CFG_MASK:   cfg_next.xor_mask     = cfg_data;
                CFG_LENGTH: cfg_next.frame_length = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte    <= FLAG_RESET;
            cfg_reg.escape_byte  <= ESCAPE_RESET;
            cfg_reg.xor_mask     <= MASK_RESET;
            cfg_reg.frame_length <= LENGTH_RESET;
            state_reg            <= '0;
            stage_valid_reg      <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (stage_fire)
            begin
                state_reg <= state_next;
            end
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (stage_fire && result.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg <= rx_byte;
        end
        if (stage_fire && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = out_reg.data_byte;
    assign byte_index    = out_reg.byte_index;
    assign last_of_frame = out_reg.last_of_frame;
    assign error_total   = out_reg.error_total;

endmodule

FILE: src/bfr_checker.sv
// port level checks for the byte stuffed frame receiver
module bfr_checker
    import bfr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [BYTE_W-1:0]      data_byte,
    input logic [COUNT_W-1:0]     byte_index,
    input logic                   last_of_frame,
    input logic [ERR_W-1:0]       error_total
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte)
            && $stable(byte_index) && $stable(last_of_frame) && $stable(error_total))
    else $error("stalled result item changed");

    // an empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

    // a result item on an empty output with no input offered needs in_ready to have been high
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_valid |=> !out_valid || $past(in_ready))
    else $error("result item appeared without a pending item");

endmodule

bind byte_stuffed_frame_receiver_top bfr_checker u_bfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .last_of_frame (last_of_frame),
    .error_total   (error_total)
);

FILE: sim/deframe_checker.sv
`timescale 1ns / 100ps
// checker for the frame receiver: predicts decoded bytes and compares them with the output
module deframe_checker
    import bfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic [COUNT_W-1:0]     byte_index,
    input  logic                   last_of_frame,
    input  logic [ERR_W-1:0]       error_total,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     byte_count,
    output int                     decoded_count,
    output int                     frame_count
);

    // past this many mismatches the rest are only counted
    localparam int REPORT_LIMIT = 40;

    cfg_t    settings;
    state_t  rx_state;
    result_t expected_bytes[$];

    // deframer prediction for one raw byte; valid marks a decoded byte
    function automatic result_t deframe_byte(input logic [BYTE_W-1:0] raw);
        result_t            r;
        logic [COUNT_W-1:0] next_count;
        r = '0;
        if (!rx_state.in_frame)
        begin
            // hunting: the byte after an escape is swallowed unchecked
            if (rx_state.escape_pending)
            begin
                rx_state.escape_pending = 1'b0;
            end
            else if (raw == settings.escape_byte)
            begin
                rx_state.escape_pending = 1'b1;
                rx_state.error_pending  = 1'b1;
            end
            else if (raw == settings.flag_byte)
            begin
                if (rx_state.error_pending)
                    rx_state.error_counter = rx_state.error_counter + ERR_W'(1);
                rx_state.error_pending  = 1'b0;
                rx_state.received_count = '0;
                rx_state.in_frame       = 1'b1;
            end
            else
            begin
                rx_state.error_pending = 1'b1;
            end
        end
        else if (!rx_state.escape_pending && raw == settings.escape_byte)
        begin
            rx_state.escape_pending = 1'b1;
        end
        else
        begin
            // data byte, unmasked if it follows an escape
            r.valid         = 1'b1;
            r.data_byte     = rx_state.escape_pending ? (raw ^ settings.xor_mask) : raw;
            rx_state.escape_pending = 1'b0;
            r.byte_index    = rx_state.received_count;
            next_count      = rx_state.received_count + COUNT_W'(1);
            r.last_of_frame = (next_count == settings.frame_length);
            r.error_total   = rx_state.error_counter;
            if (r.last_of_frame)
            begin
                rx_state.received_count = '0;
                rx_state.in_frame       = 1'b0;
            end
            else
            begin
                rx_state.received_count = next_count;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t predicted;
        if (!rst_n)
        begin
            settings       = '{FLAG_RESET, ESCAPE_RESET, MASK_RESET, LENGTH_RESET};
            rx_state       = '0;
            expected_bytes.delete();
            fail_count     = 0;
            pending        = 0;
            byte_count     = 0;
            decoded_count  = 0;
            frame_count    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_FLAG:   settings.flag_byte    = cfg_data;
                    CFG_ESCAPE: settings.escape_byte  = cfg_data;
                    CFG_MASK:   settings.xor_mask     = cfg_data;
                    CFG_LENGTH: settings.frame_length = cfg_data;
                    default:    ;
                endcase
            end

            // decoded byte leaves the block
            if (out_valid && out_ready)
            begin
                decoded_count++;
                if (expected_bytes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("data_byte: nothing expected, got %0d at index %0d",
                               data_byte, byte_index);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (data_byte !== want.data_byte)
                        report_mismatch("data_byte", int'(want.data_byte),
                                        int'(data_byte));
                    if (byte_index !== want.byte_index)
                        report_mismatch("byte_index", int'(want.byte_index),
                                        int'(byte_index));
                    if (last_of_frame !== want.last_of_frame)
                        report_mismatch("last_of_frame", int'(want.last_of_frame),
                                        int'(last_of_frame));
                    if (error_total !== want.error_total)
                        report_mismatch("error_total", int'(want.error_total),
                                        int'(error_total));
                    if (want.last_of_frame)
                        frame_count++;
                end
            end

            // raw byte enters the block
            if (in_valid && in_ready)
            begin
                byte_count++;
                predicted = deframe_byte(rx_byte);
                if (predicted.valid)
                    expected_bytes.push_back(predicted);
            end

            pending = expected_bytes.size();
        end
    end

endmodule

FILE: sim/byte_stuffed_frame_receiver_top_tb.sv
`timescale 1ns / 100ps
// testbench top for the frame receiver: byte stimulus, output stalls, watchdog and verdict
module byte_stuffed_frame_receiver_top_tb
    import bfr_pkg::*;
;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 240;
    localparam int PHASE_BYTES  = 80;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 4;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [BYTE_W-1:0]      data_byte;
    logic [COUNT_W-1:0]     byte_index;
    logic                   last_of_frame;
    logic [ERR_W-1:0]       error_total;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    int fail_count;
    int pending;
    int byte_count;
    int decoded_count;
    int frame_count;

    // register values as last written, used to shape frames
    logic [BYTE_W-1:0]  cur_flag = FLAG_RESET;
    logic [BYTE_W-1:0]  cur_esc  = ESCAPE_RESET;
    logic [BYTE_W-1:0]  cur_mask = MASK_RESET;
    logic [COUNT_W-1:0] cur_len  = LENGTH_RESET;

    int burst_left    = 0;
    int gap_len       = 0;
    int bytes_sent    = 0;
    int hold_requests = 0;
    int holds_done    = 0;

    byte_stuffed_frame_receiver_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .last_of_frame (last_of_frame),
        .error_total   (error_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    deframe_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .last_of_frame (last_of_frame),
        .error_total   (error_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .byte_count    (byte_count),
        .decoded_count (decoded_count),
        .frame_count   (frame_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one raw byte and wait until it is taken; starts and ends on a falling edge
    task automatic push_byte(input logic [BYTE_W-1:0] raw);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        burst_left--;
        if (gap_len > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
            gap_len = 0;
        end
        in_valid <= 1'b1;
        rx_byte  <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // stop offering and wait for every decoded byte plus the pipeline latency
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // rewrite all four registers back to back
    task automatic write_settings(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc,
                                  input logic [BYTE_W-1:0] mask, input logic [COUNT_W-1:0] len);
        cur_flag = flag;
        cur_esc  = esc;
        cur_mask = mask;
        cur_len  = len;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FLAG;
        cfg_data  <= flag;
        @(negedge clk);
        cfg_index <= CFG_ESCAPE;
        cfg_data  <= esc;
        @(negedge clk);
        cfg_index <= CFG_MASK;
        cfg_data  <= mask;
        @(negedge clk);
        cfg_index <= CFG_LENGTH;
        cfg_data  <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // byte biased toward the flag and escape values
    function automatic logic [BYTE_W-1:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return cur_flag;
        else if (sel < 3)
            return cur_esc;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    // one data byte, stuffed when it collides with the escape value or at random
    task automatic send_data(input logic [BYTE_W-1:0] value);
        if (value == cur_esc || $urandom_range(0, 5) == 0)
        begin
            push_byte(cur_esc);
            push_byte(value ^ cur_mask);
        end
        else
        begin
            push_byte(value);
        end
    endtask

    task automatic offer_frame(input int count);
        push_byte(cur_flag);
        repeat (count) send_data(pick_byte());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) push_byte(pick_byte());
    endtask

    // main stimulus
    initial
    begin
        logic [BYTE_W-1:0]  f;
        logic [BYTE_W-1:0]  e;
        logic [COUNT_W-1:0] len;
        int                 random_start;
        int                 phase_start;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FLAG;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: noise, escape while hunting swallowing a flag, then one full frame
        push_byte(8'h00);
        push_byte(8'h7d);
        push_byte(8'h7e);
        push_byte(8'hff);
        push_byte(8'h7e);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'h7e);
        push_byte(8'h7d);
        push_byte(8'h7d);
        push_byte(8'h7d);
        push_byte(8'h5e);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(8'hab);

        // extreme register values, one-byte frames, flag value kept as data
        settle();
        write_settings(8'h00, 8'hff, 8'hff, 8'd1);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);

        // escape equal to flag: the block never leaves hunting
        settle();
        write_settings(8'h55, 8'h55, 8'h00, 8'd3);
        push_byte(8'h55);
        push_byte(8'h55);
        push_byte(8'h55);
        push_byte(8'h12);
        push_byte(8'h33);

        // length zero gives a 256-byte frame
        settle();
        write_settings(8'hff, 8'h00, 8'h80, 8'd0);
        offer_frame(256);

        // length changed mid-frame above the count, then below it so it wraps through 256
        settle();
        write_settings(FLAG_RESET, ESCAPE_RESET, MASK_RESET, LENGTH_RESET);
        offer_frame(3);
        settle();
        write_settings(FLAG_RESET, ESCAPE_RESET, MASK_RESET, 8'd5);
        repeat (2) send_data(pick_byte());
        offer_frame(4);
        settle();
        write_settings(FLAG_RESET, ESCAPE_RESET, MASK_RESET, 8'd2);
        repeat (254) send_data(pick_byte());

        // random settings, mostly well-formed frames with noise between them
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            settle();
            f = BYTE_W'($urandom_range(0, 255));
            e = BYTE_W'($urandom_range(0, 255));
            if (e == f)
                e = f + 8'd1;
            len = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(1, 12))
                                             : COUNT_W'($urandom_range(13, 40));
            write_settings(f, e, BYTE_W'($urandom_range(0, 255)), len);
            hold_requests++;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(0, 3) != 0)
                    offer_frame(int'(cur_len));
                else
                    send_noise();
            end
        end

        settle();
        $display("%0d raw bytes in, %0d decoded bytes checked, %0d frames closed",
                 byte_count, decoded_count, frame_count);
        $display("%s%s", "settings: reset values, register extremes, flag equal to escape, ",
                 "256-byte frame, mid-frame length change, random frames under output stalls");
        if (fail_count == 0 && pending == 0)
            $display("byte_stuffed_frame_receiver_top_tb: done, clean");
        else
            $display("byte_stuffed_frame_receiver_top_tb: done, errors");
        $finish;
    end

    // output stalls: changing patterns, plus a long hold-off on request
    initial
    begin
        int seg_left;
        int seg_mode;
        int tick;
        seg_left  = 0;
        seg_mode  = 0;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (holds_done != hold_requests)
            begin
                // sender keeps offering while the output is blocked
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (seg_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (tick % 3 == 0);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no traffic on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("byte_stuffed_frame_receiver_top_tb: done, errors");
        $finish;
    end

endmodule
